[src/sit_pkg.sv]
// sit_pkg: shared types and constants of the sphere impostor texel generator
// no dependencies
`timescale 1ns / 1ps

package sit_pkg;

   localparam int DEFAULT_MAX_SIZE = 1024;
   localparam int COL_W            = 10;
   localparam int SIZE_W           = 11;
   localparam int QUO_W            = 16;
   localparam int LANES            = 4;
   localparam int ROOTS            = 2;
   localparam int REQ_DATA_W       = 24;
   localparam int RSP_DATA_W       = 48;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd64;
   localparam logic [SIZE_W-1:0] SIZE_MIN   = 11'd2;
   localparam logic [7:0] BIAS      = 8'd128;
   localparam logic [7:0] FULL_BYTE = 8'd255;

   // register indexes
   localparam logic CSR_SIZE_IN_USE  = 1'b0;
   localparam logic CSR_CYLINDER     = 1'b1;

   // division lanes
   localparam int LANE_X     = 0;
   localparam int LANE_Y     = 1;
   localparam int LANE_Z     = 2;
   localparam int LANE_DEPTH = 3;

   typedef struct packed {
      logic neg_a;
      logic neg_b;
      logic d_pos;
      logic opaque;
   } sit_flags_type;

endpackage

[src/sit_sqrt_cell.sv]
// sit_sqrt_cell: one restoring square root step for two radicands
// depends on sit_pkg
`timescale 1ns / 1ps

module sit_sqrt_cell
   import sit_pkg::*;
#(
   parameter int SW  = 10,
   parameter int RW  = 26,
   parameter int BIT = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  sit_flags_type                      in_flags,
   input  logic [SW-1:0]                      in_s,
   input  logic [ROOTS-1:0][RW-1:0]           in_pass,
   input  logic [ROOTS-1:0][2*RW-1:0]         in_rem,
   input  logic [ROOTS-1:0][RW-1:0]           in_root,
   output logic                               out_valid,
   output sit_flags_type                      out_flags,
   output logic [SW-1:0]                      out_s,
   output logic [ROOTS-1:0][RW-1:0]           out_pass,
   output logic [ROOTS-1:0][2*RW-1:0]         out_rem,
   output logic [ROOTS-1:0][RW-1:0]           out_root
);

   logic                       valid_ff;
   sit_flags_type              flags_ff;
   logic [SW-1:0]              s_ff;
   logic [ROOTS-1:0][RW-1:0]   pass_ff;
   logic [ROOTS-1:0][2*RW-1:0] rem_ff, rem_in;
   logic [ROOTS-1:0][RW-1:0]   root_ff, root_in;
   logic [2*RW:0]              trial;

   always_comb begin
      for (int i = 0; i < ROOTS; i++) begin
         trial = ((2*RW+1)'(in_root[i]) << (BIT + 1)) + ((2*RW+1)'(1) << (2 * BIT));
         if ((2*RW+1)'(in_rem[i]) >= trial) begin
            rem_in[i]  = in_rem[i] - (2*RW)'(trial);
            root_in[i] = in_root[i] | (RW'(1) << BIT);
         end else begin
            rem_in[i]  = in_rem[i];
            root_in[i] = in_root[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flags_ff <= in_flags;
         s_ff     <= in_s;
         pass_ff  <= in_pass;
         rem_ff   <= rem_in;
         root_ff  <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_s     = s_ff;
   assign out_pass  = pass_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

endmodule

[src/sit_div_cell.sv]
// sit_div_cell: one restoring division step for four dividends by s
// depends on sit_pkg
`timescale 1ns / 1ps

module sit_div_cell
   import sit_pkg::*;
#(
   parameter int SW  = 10,
   parameter int RW  = 26,
   parameter int BIT = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  sit_flags_type                  in_flags,
   input  logic [SW-1:0]                  in_s,
   input  logic [LANES-1:0][RW-1:0]       in_rem,
   input  logic [LANES-1:0][QUO_W-1:0]    in_quo,
   output logic                           out_valid,
   output sit_flags_type                  out_flags,
   output logic [SW-1:0]                  out_s,
   output logic [LANES-1:0][RW-1:0]       out_rem,
   output logic [LANES-1:0][QUO_W-1:0]    out_quo
);

   logic                        valid_ff;
   sit_flags_type               flags_ff;
   logic [SW-1:0]               s_ff;
   logic [LANES-1:0][RW-1:0]    rem_ff, rem_in;
   logic [LANES-1:0][QUO_W-1:0] quo_ff, quo_in;
   logic [RW-1:0]               shifted;

   assign shifted = RW'(in_s) << BIT;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (in_rem[i] >= shifted) begin
            rem_in[i] = in_rem[i] - shifted;
            quo_in[i] = in_quo[i] | (QUO_W'(1) << BIT);
         end else begin
            rem_in[i] = in_rem[i];
            quo_in[i] = in_quo[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flags_ff <= in_flags;
         s_ff     <= in_s;
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_s     = s_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;

endmodule

[src/sphere_impostor_texel_generator_core.sv]
// sphere_impostor_texel_generator_core: top level, operand stages, cell chains, output register
// throughput: one word per cycle while not stalled, set by the square root and division cell rows
// the pipeline stalls only when a finished result waits and the last cell holds a word
// reset: synchronous, clears all valid bits, size_in_use to 64, cylinder_mode to 0
`timescale 1ns / 1ps

module sphere_impostor_texel_generator_core
   import sit_pkg::*;
#(
   parameter int MAX_SIZE = DEFAULT_MAX_SIZE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_addr,
   input  logic [SIZE_W-1:0]     csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // column, row
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // normal_x, normal_y, normal_z, opacity, depth
);

   localparam int SW = (MAX_SIZE > 2) ? $clog2(MAX_SIZE) : 1;
   localparam int ZW = (SW + 1 > SIZE_W) ? SW + 1 : SIZE_W;
   localparam int MW = (SW > COL_W + 1) ? SW : COL_W + 1;
   localparam int RW = SW + QUO_W;

   logic [SIZE_W-1:0] size_ff;
   logic              cyl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         cyl_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SIZE_IN_USE: size_ff <= csr_wdata;
            CSR_CYLINDER:    cyl_ff  <= csr_wdata[0];
            default:         ;
         endcase
      end
   end

   logic adv, tail_valid;
   assign req_tready = adv;

   // stage 0: capture word and clamped s
   logic [ZW-1:0]    size_c;
   logic             v0_ff;
   logic [COL_W-1:0] col0_ff, row0_ff;
   logic [SW-1:0]    s0_ff;
   logic             cyl0_ff;

   always_comb begin
      if (size_ff < SIZE_MIN) begin
         size_c = ZW'(SIZE_MIN);
      end else if (ZW'(size_ff) > ZW'(MAX_SIZE)) begin
         size_c = ZW'(MAX_SIZE);
      end else begin
         size_c = ZW'(size_ff);
      end
   end

   // stage 1: magnitudes of a and b
   logic          v1_ff, neg_a1_ff, neg_b1_ff, cyl1_ff;
   logic [MW-1:0] abs_a1_ff, abs_b1_ff, abs_a_in, abs_b_in;
   logic [SW-1:0] s1_ff;
   logic [MW-1:0] col2, row2, s_m;

   assign col2 = MW'({col0_ff, 1'b0});
   assign row2 = MW'({row0_ff, 1'b0});
   assign s_m  = MW'(s0_ff);

   always_comb begin
      abs_a_in = (col2 < s_m) ? s_m - col2 : col2 - s_m;
      if (cyl0_ff) begin
         abs_b_in = '0;
      end else begin
         abs_b_in = (row2 < s_m) ? s_m - row2 : row2 - s_m;
      end
   end

   // stage 2: squares
   logic            v2_ff, neg_a2_ff, neg_b2_ff, cyl2_ff;
   logic [MW-1:0]   abs_a2_ff, abs_b2_ff;
   logic [SW-1:0]   s2_ff;
   logic [2*MW-1:0] asq_ff, bsq_ff, ssq_ff;

   // stage 3: discriminant
   logic            v3_ff, neg_a3_ff, neg_b3_ff, pos3_ff, opq3_ff;
   logic [MW-1:0]   abs_a3_ff, abs_b3_ff;
   logic [SW-1:0]   s3_ff;
   logic [2*SW-1:0] d3_ff;
   logic [2*MW:0]   sum_ab, ssq_w;
   logic            d_pos_c, d_zero_c;

   assign sum_ab   = (2*MW+1)'(asq_ff) + (2*MW+1)'(bsq_ff);
   assign ssq_w    = (2*MW+1)'(ssq_ff);
   assign d_pos_c  = ssq_w > sum_ab;
   assign d_zero_c = ssq_w == sum_ab;

   // stage 4: radicands and numerators, feeds the square root row
   logic [2*RW-1:0] d_w;
   assign d_w = (2*RW)'(d3_ff);

   logic                       sq_v    [RW+1];
   sit_flags_type              sq_f    [RW+1];
   logic [SW-1:0]              sq_s    [RW+1];
   logic [ROOTS-1:0][RW-1:0]   sq_pass [RW+1];
   logic [ROOTS-1:0][2*RW-1:0] sq_rem  [RW+1];
   logic [ROOTS-1:0][RW-1:0]   sq_root [RW+1];
   logic [MW+6:0]              num_a, num_b;

   assign num_a = ((MW+7)'(abs_a3_ff) << 7) - (MW+7)'(abs_a3_ff);
   assign num_b = ((MW+7)'(abs_b3_ff) << 7) - (MW+7)'(abs_b3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         sq_v[0]  <= 1'b0;
      end else if (adv) begin
         v0_ff    <= req_tvalid;
         v1_ff    <= v0_ff;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         sq_v[0]  <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         col0_ff   <= req_tdata[COL_W-1:0];
         row0_ff   <= req_tdata[2*COL_W-1:COL_W];
         s0_ff     <= SW'(size_c - ZW'(1));
         cyl0_ff   <= cyl_ff;

         abs_a1_ff <= abs_a_in;
         abs_b1_ff <= abs_b_in;
         neg_a1_ff <= col2 < s_m;
         neg_b1_ff <= !cyl0_ff && (row2 < s_m);
         s1_ff     <= s0_ff;
         cyl1_ff   <= cyl0_ff;

         asq_ff    <= abs_a1_ff * abs_a1_ff;
         bsq_ff    <= abs_b1_ff * abs_b1_ff;
         ssq_ff    <= (2*MW)'(s1_ff) * (2*MW)'(s1_ff);
         abs_a2_ff <= abs_a1_ff;
         abs_b2_ff <= abs_b1_ff;
         neg_a2_ff <= neg_a1_ff;
         neg_b2_ff <= neg_b1_ff;
         s2_ff     <= s1_ff;
         cyl2_ff   <= cyl1_ff;

         d3_ff     <= d_pos_c ? (2*SW)'(ssq_w - sum_ab) : '0;
         pos3_ff   <= d_pos_c;
         opq3_ff   <= d_pos_c || (d_zero_c && !cyl2_ff);
         abs_a3_ff <= d_pos_c ? abs_a2_ff : '0;
         abs_b3_ff <= d_pos_c ? abs_b2_ff : '0;
         neg_a3_ff <= neg_a2_ff;
         neg_b3_ff <= neg_b2_ff;
         s3_ff     <= s2_ff;

         sq_f[0]       <= '{neg_a: neg_a3_ff, neg_b: neg_b3_ff,
                            d_pos: pos3_ff, opaque: opq3_ff};
         sq_s[0]       <= s3_ff;
         sq_pass[0][0] <= RW'(num_a);
         sq_pass[0][1] <= RW'(num_b);
         sq_rem[0][0]  <= (d_w << 14) - (d_w << 8) + d_w;
         sq_rem[0][1]  <= (d_w << 32) - (d_w << 17) + d_w;
         sq_root[0]    <= '0;
      end
   end

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      sit_sqrt_cell #(
         .SW  (SW),
         .RW  (RW),
         .BIT (RW - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (sq_v[k]),
         .in_flags  (sq_f[k]),
         .in_s      (sq_s[k]),
         .in_pass   (sq_pass[k]),
         .in_rem    (sq_rem[k]),
         .in_root   (sq_root[k]),
         .out_valid (sq_v[k+1]),
         .out_flags (sq_f[k+1]),
         .out_s     (sq_s[k+1]),
         .out_pass  (sq_pass[k+1]),
         .out_rem   (sq_rem[k+1]),
         .out_root  (sq_root[k+1])
      );
   end

   logic                        dv_v   [QUO_W+1];
   sit_flags_type               dv_f   [QUO_W+1];
   logic [SW-1:0]               dv_s   [QUO_W+1];
   logic [LANES-1:0][RW-1:0]    dv_rem [QUO_W+1];
   logic [LANES-1:0][QUO_W-1:0] dv_quo [QUO_W+1];

   assign dv_v[0]              = sq_v[RW];
   assign dv_f[0]              = sq_f[RW];
   assign dv_s[0]              = sq_s[RW];
   assign dv_rem[0][LANE_X]     = sq_pass[RW][0];
   assign dv_rem[0][LANE_Y]     = sq_pass[RW][1];
   assign dv_rem[0][LANE_Z]     = sq_root[RW][0];
   assign dv_rem[0][LANE_DEPTH] = sq_root[RW][1];
   assign dv_quo[0]            = '0;

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      sit_div_cell #(
         .SW  (SW),
         .RW  (RW),
         .BIT (QUO_W - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (dv_v[k]),
         .in_flags  (dv_f[k]),
         .in_s      (dv_s[k]),
         .in_rem    (dv_rem[k]),
         .in_quo    (dv_quo[k]),
         .out_valid (dv_v[k+1]),
         .out_flags (dv_f[k+1]),
         .out_s     (dv_s[k+1]),
         .out_rem   (dv_rem[k+1]),
         .out_quo   (dv_quo[k+1])
      );
   end

   // output register
   sit_flags_type               tf;
   logic [LANES-1:0][QUO_W-1:0] tq;
   logic [LANES-1:0][RW-1:0]    tr;
   logic [7:0]                  nx, ny, nz, op;
   logic [15:0]                 dep;
   logic                        rsp_v_ff, rsp_v_in, out_load;
   logic [RSP_DATA_W-1:0]       rsp_d_ff;

   assign tail_valid = dv_v[QUO_W];
   assign tf         = dv_f[QUO_W];
   assign tq         = dv_quo[QUO_W];
   assign tr         = dv_rem[QUO_W];
   assign adv        = !tail_valid || !rsp_v_ff || rsp_tready;
   assign out_load   = tail_valid && (!rsp_v_ff || rsp_tready);

   always_comb begin
      if (!tf.d_pos) begin
         nx = BIAS;
      end else if (tf.neg_a) begin
         nx = BIAS - tq[LANE_X][7:0] - 8'(tr[LANE_X] != '0);
      end else begin
         nx = BIAS + tq[LANE_X][7:0];
      end
      if (!tf.d_pos) begin
         ny = BIAS;
      end else if (tf.neg_b) begin
         ny = BIAS - tq[LANE_Y][7:0] - 8'(tr[LANE_Y] != '0);
      end else begin
         ny = BIAS + tq[LANE_Y][7:0];
      end
      nz  = tf.d_pos ? BIAS + tq[LANE_Z][7:0] : FULL_BYTE;
      dep = tf.d_pos ? tq[LANE_DEPTH] : 16'd0;
      op  = tf.opaque ? FULL_BYTE : 8'd0;
   end

   always_comb begin
      if (out_load) begin
         rsp_v_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_v_in = 1'b0;
      end else begin
         rsp_v_in = rsp_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_d_ff <= {dep, op, nz, ny, nx};
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

endmodule
